// ===== design/tdm_pkg.sv =====
// shared types and constants for the task deadline monitor
package tdm_pkg;

   // fixed field widths
   localparam int unsigned TASK_SLOTS = 5;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;

   typedef logic [TASK_SLOTS-1:0] task_mask_type;
   typedef logic [TICK_W-1:0]     tick_type;
   typedef logic [HALF_W-1:0]     half_type;
   typedef logic [HALF_W:0]       limit_type;
   typedef logic [1:0]            op_type;
   typedef logic [2:0]            task_id_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // operation codes
   localparam op_type OP_ENTER = 2'd0;
   localparam op_type OP_EXIT  = 2'd1;
   localparam op_type OP_CHECK = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_TASK_ENABLE   = 3'd0;
   localparam csr_idx_type CSR_RECORD_ENABLE = 3'd1;
   localparam csr_idx_type CSR_TIMING_BASE   = 3'd2;

endpackage

// ===== design/task_deadline_monitor.sv =====
// task deadline monitor: entry/exit timing, periodic deadline check, violation record
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  operation, task_id, timestamp
//   rsp_     out        rsp_valid/rsp_stall  violation_mask, check_skipped,
//                                            record_changed, recorded_any, recorded_mask
//   csr_     in         csr_valid/csr_ready  index, wdata
//
// one item per cycle sustained while the result side does not stall; a result passes the
// input register, then the result register, before it is valid.
// all task state sits in flip-flops and is updated in the cycle the item moves from the
// input register to the result register.
// synchronous active-high reset clears every register except the payload stages.
// a stalled result holds; the input register keeps taking items while the result
// register is empty or draining, so req_stall only rises when both stages are full.
module task_deadline_monitor #(
   parameter int unsigned NUM_TASKS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tdm_pkg::op_type            req_operation,
   input  tdm_pkg::task_id_type       req_task_id,
   input  tdm_pkg::tick_type          req_timestamp,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tdm_pkg::task_mask_type     rsp_violation_mask,
   output logic                       rsp_check_skipped,
   output logic                       rsp_record_changed,
   output logic                       rsp_recorded_any,
   output tdm_pkg::task_mask_type     rsp_recorded_mask,
   // configuration port
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  tdm_pkg::csr_idx_type       csr_index,
   input  tdm_pkg::tick_type          csr_wdata
);

   // configuration
   tdm_pkg::task_mask_type task_enable_ff;
   tdm_pkg::task_mask_type record_enable_ff;
   tdm_pkg::tick_type      timing_ff [NUM_TASKS];

   // input register
   logic                   in_valid_ff;
   tdm_pkg::op_type        op_ff;
   tdm_pkg::task_id_type   id_ff;
   tdm_pkg::tick_type      ts_ff;

   // task state
   tdm_pkg::tick_type      enter_time_ff    [NUM_TASKS];
   tdm_pkg::tick_type      enter_time_in    [NUM_TASKS];
   tdm_pkg::tick_type      last_dur_ff      [NUM_TASKS];
   tdm_pkg::tick_type      last_dur_in      [NUM_TASKS];
   tdm_pkg::tick_type      rec_dur_ff       [NUM_TASKS];
   tdm_pkg::tick_type      rec_dur_in       [NUM_TASKS];
   tdm_pkg::tick_type      rec_enter_ff     [NUM_TASKS];
   tdm_pkg::tick_type      rec_enter_in     [NUM_TASKS];
   tdm_pkg::tick_type      last_check_ff;
   tdm_pkg::tick_type      last_check_in;
   logic                   rec_any_ff;
   logic                   rec_any_in;

   // per-task check terms
   tdm_pkg::limit_type     limit_sum [NUM_TASKS];
   tdm_pkg::tick_type      since_time [NUM_TASKS];
   logic                   late      [NUM_TASKS];

   // result register
   logic                   rsp_valid_ff;
   tdm_pkg::task_mask_type viol_ff;
   tdm_pkg::task_mask_type viol_in;
   logic                   skipped_ff;
   logic                   skipped_in;
   logic                   changed_ff;
   logic                   changed_in;
   tdm_pkg::task_mask_type rec_mask_ff;
   tdm_pkg::task_mask_type rec_mask_in;

   logic                   fire;

   // pipeline handshake
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         task_enable_ff   <= '0;
         record_enable_ff <= '0;
         for (int t = 0; t < NUM_TASKS; t++) begin
            timing_ff[t] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tdm_pkg::CSR_TASK_ENABLE) begin
            task_enable_ff <= csr_wdata[tdm_pkg::TASK_SLOTS-1:0];
         end
         if (csr_index == tdm_pkg::CSR_RECORD_ENABLE) begin
            record_enable_ff <= csr_wdata[tdm_pkg::TASK_SLOTS-1:0];
         end
         for (int t = 0; t < NUM_TASKS; t++) begin
            if (csr_index == tdm_pkg::csr_idx_type'(t + 2)) begin
               timing_ff[t] <= csr_wdata;
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         op_ff <= req_operation;
         id_ff <= req_task_id;
         ts_ff <= req_timestamp;
      end
   end

   // deadline terms per task: limit never wraps, elapsed time wraps mod 2^32
   always_comb begin
      for (int t = 0; t < NUM_TASKS; t++) begin
         limit_sum[t]  = {1'b0, timing_ff[t][tdm_pkg::HALF_W-1:0]}
                       + {1'b0, timing_ff[t][tdm_pkg::TICK_W-1:tdm_pkg::HALF_W]};
         since_time[t] = ts_ff - enter_time_ff[t];
         late[t]       = task_enable_ff[t]
                       && (since_time[t] > {{(tdm_pkg::TICK_W-tdm_pkg::HALF_W-1){1'b0}},
                                            limit_sum[t]})
                       && (last_dur_ff[t] > {{(tdm_pkg::TICK_W-tdm_pkg::HALF_W){1'b0}},
                                            timing_ff[t][tdm_pkg::HALF_W-1:0]});
      end
   end

   // next state and result for the item in the input register
   always_comb begin
      enter_time_in = enter_time_ff;
      last_dur_in   = last_dur_ff;
      rec_dur_in    = rec_dur_ff;
      rec_enter_in  = rec_enter_ff;
      last_check_in = last_check_ff;
      rec_any_in    = rec_any_ff;
      viol_in       = '0;
      skipped_in    = 1'b0;
      changed_in    = 1'b0;
      case (op_ff)
         tdm_pkg::OP_ENTER: begin
            for (int t = 0; t < NUM_TASKS; t++) begin
               if (id_ff == tdm_pkg::task_id_type'(t)) begin
                  enter_time_in[t] = ts_ff;
               end
            end
         end
         tdm_pkg::OP_EXIT: begin
            for (int t = 0; t < NUM_TASKS; t++) begin
               if (id_ff == tdm_pkg::task_id_type'(t)) begin
                  last_dur_in[t] = ts_ff - enter_time_ff[t];
               end
            end
         end
         tdm_pkg::OP_CHECK: begin
            if (ts_ff == last_check_ff) begin
               skipped_in = 1'b1;
            end else begin
               last_check_in = ts_ff;
               for (int t = 0; t < NUM_TASKS; t++) begin
                  if (late[t]) begin
                     viol_in[t] = 1'b1;
                     if (record_enable_ff[t]) begin
                        changed_in      = 1'b1;
                        rec_any_in      = 1'b1;
                        rec_dur_in[t]   = last_dur_ff[t];
                        rec_enter_in[t] = enter_time_ff[t];
                     end
                  end
               end
            end
         end
         tdm_pkg::OP_CLEAR: begin
            rec_any_in = 1'b0;
            changed_in = 1'b1;
            for (int t = 0; t < NUM_TASKS; t++) begin
               rec_dur_in[t]   = '0;
               rec_enter_in[t] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // recorded mask from the record after this item
   always_comb begin
      rec_mask_in = '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
         rec_mask_in[t] = rec_any_in && ((rec_dur_in[t] != '0) || (rec_enter_in[t] != '0));
      end
   end

   // task state update on each item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_check_ff <= '0;
         rec_any_ff    <= 1'b0;
         for (int t = 0; t < NUM_TASKS; t++) begin
            enter_time_ff[t] <= '0;
            last_dur_ff[t]   <= '0;
            rec_dur_ff[t]    <= '0;
            rec_enter_ff[t]  <= '0;
         end
      end else if (fire) begin
         last_check_ff <= last_check_in;
         rec_any_ff    <= rec_any_in;
         enter_time_ff <= enter_time_in;
         last_dur_ff   <= last_dur_in;
         rec_dur_ff    <= rec_dur_in;
         rec_enter_ff  <= rec_enter_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         viol_ff     <= viol_in;
         skipped_ff  <= skipped_in;
         changed_ff  <= changed_in;
         rec_mask_ff <= rec_mask_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_violation_mask = viol_ff;
   assign rsp_check_skipped  = skipped_ff;
   assign rsp_record_changed = changed_ff;
   assign rsp_recorded_any   = rec_any_ff;
   assign rsp_recorded_mask  = rec_mask_ff;

endmodule

// ===== test/testbench.sv =====
// testbench for the task deadline monitor: event traffic, predicted results, register settings
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned MON_TASKS      = 5;
   localparam int          RESULT_LATENCY = 4;
   localparam int          IDLE_LIMIT     = 2000;

   // register index past the last timing register, ignored by the block
   localparam tdm_pkg::csr_idx_type CSR_UNUSED = 3'd7;

   // one result as the block reports it
   typedef struct packed {
      tdm_pkg::task_mask_type violation_mask;
      logic                   check_skipped;
      logic                   record_changed;
      logic                   recorded_any;
      tdm_pkg::task_mask_type recorded_mask;
   } monitor_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   tdm_pkg::op_type        req_operation;
   tdm_pkg::task_id_type   req_task_id;
   tdm_pkg::tick_type      req_timestamp;
   logic                   rsp_valid;
   logic                   rsp_stall;
   tdm_pkg::task_mask_type rsp_violation_mask;
   logic                   rsp_check_skipped;
   logic                   rsp_record_changed;
   logic                   rsp_recorded_any;
   tdm_pkg::task_mask_type rsp_recorded_mask;
   logic                   csr_valid;
   logic                   csr_ready;
   tdm_pkg::csr_idx_type   csr_index;
   tdm_pkg::tick_type      csr_wdata;

   task_deadline_monitor #(
      .NUM_TASKS (MON_TASKS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_task_id        (req_task_id),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_violation_mask (rsp_violation_mask),
      .rsp_check_skipped  (rsp_check_skipped),
      .rsp_record_changed (rsp_record_changed),
      .rsp_recorded_any   (rsp_recorded_any),
      .rsp_recorded_mask  (rsp_recorded_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // predicted monitor state and settings
   tdm_pkg::task_mask_type monitor_enable;
   tdm_pkg::task_mask_type record_enable;
   tdm_pkg::tick_type      task_timing [tdm_pkg::TASK_SLOTS];
   tdm_pkg::tick_type      entry_tick [tdm_pkg::TASK_SLOTS];
   tdm_pkg::tick_type      run_length [tdm_pkg::TASK_SLOTS];
   tdm_pkg::tick_type      prev_check_tick;
   logic                   record_valid;
   tdm_pkg::tick_type      recorded_length [tdm_pkg::TASK_SLOTS];
   tdm_pkg::tick_type      recorded_entry [tdm_pkg::TASK_SLOTS];

   monitor_result_type expected_results [$];

   int  events_sent;
   int  results_checked;
   int  writes_done;
   int  flagged_results;
   int  skipped_checks;
   int  mismatches;
   int  idle_cycles;
   bit  sender_quiet;
   bit  receiver_quiet;
   tdm_pkg::tick_type tick_now;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register write as the block applies it
   function automatic void apply_register(tdm_pkg::csr_idx_type idx, tdm_pkg::tick_type data);
      case (idx)
         tdm_pkg::CSR_TASK_ENABLE: begin
            monitor_enable = data[tdm_pkg::TASK_SLOTS-1:0];
         end
         tdm_pkg::CSR_RECORD_ENABLE: begin
            record_enable = data[tdm_pkg::TASK_SLOTS-1:0];
         end
         default: begin
            if (idx >= tdm_pkg::CSR_TIMING_BASE
                && idx < tdm_pkg::CSR_TIMING_BASE + tdm_pkg::TASK_SLOTS)
               task_timing[idx - tdm_pkg::CSR_TIMING_BASE] = data;
         end
      endcase
   endfunction

   // advance the predicted state by one event and return its result
   function automatic monitor_result_type monitor_step(tdm_pkg::op_type op,
                                                       tdm_pkg::task_id_type id,
                                                       tdm_pkg::tick_type ts);
      monitor_result_type res;
      tdm_pkg::tick_type  cycle_time;
      tdm_pkg::tick_type  deadline;
      tdm_pkg::tick_type  elapsed;
      int                 t;
      res = '0;
      case (op)
         tdm_pkg::OP_ENTER: begin
            if (id < MON_TASKS)
               entry_tick[id] = ts;
         end
         tdm_pkg::OP_EXIT: begin
            if (id < MON_TASKS)
               run_length[id] = ts - entry_tick[id];
         end
         tdm_pkg::OP_CHECK: begin
            if (ts == prev_check_tick) begin
               res.check_skipped = 1'b1;
            end else begin
               prev_check_tick = ts;
               for (t = 0; t < MON_TASKS; t++) begin
                  if (monitor_enable[t]) begin
                     cycle_time = {16'h0, task_timing[t][15:0]};
                     deadline   = cycle_time + {16'h0, task_timing[t][31:16]};
                     elapsed    = ts - entry_tick[t];
                     if (elapsed > deadline && run_length[t] > cycle_time) begin
                        res.violation_mask[t] = 1'b1;
                        if (record_enable[t]) begin
                           res.record_changed = 1'b1;
                           record_valid       = 1'b1;
                           recorded_length[t] = run_length[t];
                           recorded_entry[t]  = entry_tick[t];
                        end
                     end
                  end
               end
            end
         end
         default: begin
            record_valid = 1'b0;
            for (t = 0; t < tdm_pkg::TASK_SLOTS; t++) begin
               recorded_length[t] = '0;
               recorded_entry[t]  = '0;
            end
            res.record_changed = 1'b1;
         end
      endcase
      res.recorded_any = record_valid;
      for (t = 0; t < MON_TASKS; t++)
         if (record_valid && (recorded_length[t] != 0 || recorded_entry[t] != 0))
            res.recorded_mask[t] = 1'b1;
      return res;
   endfunction

   // one event transfer on the input channel
   task automatic send_event(input tdm_pkg::op_type op, input tdm_pkg::task_id_type id,
                             input tdm_pkg::tick_type ts);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_task_id   <= id;
      req_timestamp <= ts;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(monitor_step(op, id, ts));
      events_sent++;
   endtask

   // let every outstanding result drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // one register transfer on the configuration port
   task automatic write_register(input tdm_pkg::csr_idx_type idx, input tdm_pkg::tick_type data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // program both masks and all timing registers, plus the unused index
   task automatic program_settings(input tdm_pkg::task_mask_type en,
                                   input tdm_pkg::task_mask_type rec,
                                   input int timing_kind);
      tdm_pkg::tick_type value;
      int                t;
      wait_idle();
      write_register(tdm_pkg::CSR_TASK_ENABLE, {$urandom} & 32'hFFFF_FFE0 | 32'(en));
      write_register(tdm_pkg::CSR_RECORD_ENABLE, {$urandom} & 32'hFFFF_FFE0 | 32'(rec));
      for (t = 0; t < tdm_pkg::TASK_SLOTS; t++) begin
         case (timing_kind)
            0: value = '0;
            1: value = 32'hFFFF_FFFF;
            default: value = {16'($urandom_range(0, 60)), 16'($urandom_range(0, 60))};
         endcase
         write_register(tdm_pkg::CSR_TIMING_BASE + tdm_pkg::csr_idx_type'(t), value);
      end
      write_register(CSR_UNUSED, $urandom);
   endtask

   // mostly well-formed enter/exit/check/clear traffic around a running tick, some noise
   task automatic run_traffic(input int count, input int max_step);
      int                   r;
      tdm_pkg::op_type      op;
      tdm_pkg::task_id_type id;
      tdm_pkg::tick_type    ts;
      repeat (count) begin
         r  = $urandom_range(0, 99);
         id = tdm_pkg::task_id_type'($urandom_range(0, MON_TASKS - 1));
         ts = tick_now;
         if (r < 30) begin
            op = tdm_pkg::OP_ENTER;
         end else if (r < 55) begin
            op = tdm_pkg::OP_EXIT;
         end else if (r < 80) begin
            op = tdm_pkg::OP_CHECK;
            if ($urandom_range(0, 3) == 0)
               ts = prev_check_tick;
         end else if (r < 85) begin
            op = tdm_pkg::OP_CLEAR;
         end else begin
            op = tdm_pkg::op_type'($urandom);
            id = tdm_pkg::task_id_type'($urandom);
            ts = $urandom;
         end
         send_event(op, id, ts);
         tick_now = tick_now + tdm_pkg::tick_type'($urandom_range(0, max_step));
      end
   endtask

   // compare one field of a result
   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      monitor_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, actual mask %0h", $time,
                     rsp_violation_mask);
         end else begin
            want = expected_results.pop_front();
            check_field("violation_mask", 32'(want.violation_mask), 32'(rsp_violation_mask));
            check_field("check_skipped", 32'(want.check_skipped), 32'(rsp_check_skipped));
            check_field("record_changed", 32'(want.record_changed), 32'(rsp_record_changed));
            check_field("recorded_any", 32'(want.recorded_any), 32'(rsp_recorded_any));
            check_field("recorded_mask", 32'(want.recorded_mask), 32'(rsp_recorded_mask));
            if (want.violation_mask != 0)
               flagged_results++;
            if (want.check_skipped)
               skipped_checks++;
         end
         results_checked++;
      end
   end

   // result side backpressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = receiver_quiet ? 0 : $urandom_range(0, 16);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("task_deadline_monitor: mismatch");
      $finish;
   end

   // extremes, every operation and the special cases
   task automatic test_directed_events();
      // first check at tick zero after reset is skipped
      send_event(tdm_pkg::OP_CHECK, 3'd0, 32'h0);
      wait_idle();
      write_register(tdm_pkg::CSR_TASK_ENABLE, 32'hFFFF_FFFF);
      write_register(tdm_pkg::CSR_RECORD_ENABLE, 32'hFFFF_FFFF);
      write_register(tdm_pkg::CSR_TIMING_BASE, {16'd5, 16'd10});
      write_register(CSR_UNUSED, 32'hFFFF_FFFF);
      send_event(tdm_pkg::OP_ENTER, 3'd0, 32'd100);
      send_event(tdm_pkg::OP_EXIT, 3'd0, 32'd120);
      send_event(tdm_pkg::OP_CHECK, 3'd0, 32'd116);
      // same tick again is skipped
      send_event(tdm_pkg::OP_CHECK, 3'd7, 32'd116);
      // duration across the tick wrap
      send_event(tdm_pkg::OP_ENTER, 3'd1, 32'hFFFF_FFF0);
      send_event(tdm_pkg::OP_EXIT, 3'd1, 32'h0000_0010);
      send_event(tdm_pkg::OP_CHECK, 3'd0, 32'h0000_0100);
      // task ids out of range are ignored
      send_event(tdm_pkg::OP_ENTER, 3'd5, 32'hFFFF_FFFF);
      send_event(tdm_pkg::OP_EXIT, 3'd7, 32'h0);
      send_event(tdm_pkg::OP_ENTER, 3'd6, 32'h5555_5555);
      // clear, and clear of an empty record
      send_event(tdm_pkg::OP_CLEAR, 3'd0, 32'hAAAA_AAAA);
      send_event(tdm_pkg::OP_CLEAR, 3'd7, 32'h0);
      send_event(tdm_pkg::OP_CHECK, 3'd0, 32'hFFFF_FFFF);
      send_event(tdm_pkg::OP_CHECK, 3'd0, 32'h0);
      send_event(tdm_pkg::OP_ENTER, 3'd4, 32'hFFFF_FFFF);
      send_event(tdm_pkg::OP_EXIT, 3'd4, 32'hFFFF_FFFF);
      send_event(tdm_pkg::OP_EXIT, 3'd4, 32'hFFFF_FFFE);
      send_event(tdm_pkg::OP_ENTER, 3'd2, 32'h0);
      send_event(tdm_pkg::OP_EXIT, 3'd2, 32'h8000_0000);
      send_event(tdm_pkg::OP_CHECK, 3'd3, 32'h8000_0000);
      send_event(tdm_pkg::OP_CHECK, 3'd3, 32'h8000_0001);
   endtask

   // random traffic over several register settings
   task automatic test_random_traffic();
      int p;
      for (p = 0; p < 6; p++) begin
         sender_quiet   = (p == 2);
         receiver_quiet = (p == 4);
         case (p)
            0: program_settings(5'h1F, 5'h1F, 0);
            1: program_settings(5'h00, 5'h1F, 2);
            2: program_settings(5'h1F, 5'h00, 2);
            3: program_settings(5'h1F, 5'h1F, 1);
            default: program_settings(tdm_pkg::task_mask_type'($urandom),
                                      tdm_pkg::task_mask_type'($urandom), 2);
         endcase
         tick_now = $urandom_range(0, 1000);
         run_traffic(130, 40);
      end
   endtask

   // ticks running across the 32-bit wrap
   task automatic test_tick_wrap();
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      program_settings(5'h1F, 5'h1F, 2);
      tick_now = 32'hFFFF_FC00;
      run_traffic(150, 40);
   endtask

   initial begin
      int t;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = tdm_pkg::OP_ENTER;
      req_task_id    = '0;
      req_timestamp  = '0;
      csr_valid      = 1'b0;
      csr_index      = tdm_pkg::CSR_TASK_ENABLE;
      csr_wdata      = '0;
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      monitor_enable  = '0;
      record_enable   = '0;
      prev_check_tick = '0;
      record_valid    = 1'b0;
      for (t = 0; t < tdm_pkg::TASK_SLOTS; t++) begin
         task_timing[t]     = '0;
         entry_tick[t]      = '0;
         run_length[t]      = '0;
         recorded_length[t] = '0;
         recorded_entry[t]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_events();
      test_random_traffic();
      test_tick_wrap();
      wait_idle();

      $display("events %0d, results %0d, register writes %0d", events_sent,
               results_checked, writes_done);
      $display("results with violations %0d, skipped checks %0d, mismatches %0d",
               flagged_results, skipped_checks, mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("task_deadline_monitor: match");
      else
         $display("task_deadline_monitor: mismatch");
      $finish;
   end

endmodule
